@@ hw/rtl/pointer_position_tracker_defines.svh @@
// Assertion macros shared by the pointer position tracker RTL.
// Expects clk and arst_n in the scope of every use.
`ifndef POINTER_POSITION_TRACKER_DEFINES_SVH
`define POINTER_POSITION_TRACKER_DEFINES_SVH

// property holds at every edge outside reset
`define PPT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ppt_pkg.sv @@
// Pointer position tracker package: codes, item and result types, clamp helpers.
// No dependencies; used by every module of the tracker.
`default_nettype none

package ppt_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd640;
	localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd480;
	localparam logic [12:0] SCREEN_LIMIT      = 13'd4096;

	typedef enum logic [1:0] {
		CMD_MOTION = 2'd0,
		CMD_BUTTON = 2'd1,
		CMD_READ   = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ACT_RELEASE = 2'd0,
		ACT_PRESS   = 2'd1
	} act_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_MOTION = 2'd1,
		EV_DOWN   = 2'd2,
		EV_UP     = 2'd3
	} ev_t;

	typedef enum logic [2:0] {
		REG_SCREEN_WIDTH   = 3'd0,
		REG_SCREEN_HEIGHT  = 3'd1,
		REG_OFFSET_X       = 3'd2,
		REG_OFFSET_Y       = 3'd3,
		REG_SURFACE        = 3'd4,
		REG_MOTION_ENABLE  = 3'd5,
		REG_PRESS_ENABLE   = 3'd6,
		REG_RELEASE_ENABLE = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_MOTION,
		OP_PRESS,
		OP_RELEASE,
		OP_READ
	} op_t;

	typedef struct packed {
		logic [12:0] screen_width;
		logic [12:0] screen_height;
		logic [11:0] offset_x;
		logic [11:0] offset_y;
		logic        surface_present;
		logic        motion_enable;
		logic        press_enable;
		logic        release_enable;
	} cfg_t;

	typedef struct packed {
		op_t         op;
		logic        relative;
		logic [15:0] dx;
		logic [15:0] dy;
		logic [11:0] abs_x;
		logic [11:0] abs_y;
		logic        use_x;
		logic        use_y;
		logic [7:0]  buttons;
		logic [7:0]  bit_mask;
		logic        posted;
	} item_t;

	typedef struct packed {
		logic        posted;
		ev_t         event_kind;
		logic [11:0] event_x;
		logic [11:0] event_y;
		logic [15:0] step_rel_x;
		logic [15:0] step_rel_y;
		logic [11:0] cur_x;
		logic [11:0] cur_y;
		logic [7:0]  cur_buttons;
		logic [15:0] sum_dx;
		logic [15:0] sum_dy;
	} result_t;

	// largest coordinate for a screen size; 0 acts as 1, above 4096 as 4096
	function automatic logic [11:0] lim_max(input logic [12:0] lim);
		logic [12:0] m;
		m = lim - 13'd1;
		if (lim == 13'd0)
			return 12'd0;
		if (lim > SCREEN_LIMIT)
			return 12'hfff;
		return m[11:0];
	endfunction

	function automatic logic [11:0] clamp_axis(input logic [15:0] v, input logic [11:0] mx);
		if (v[15])
			return 12'd0;
		if (v[14:0] > {3'd0, mx})
			return mx;
		return v[11:0];
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ppt_front.sv @@
// Front end: takes input beats, decodes the command and prepares the
// state-independent parts (absolute clamp, button bit, post enable). Uses ppt_pkg.
`default_nettype none

module ppt_front (
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic               relative,
	input  wire logic [15:0]        pos_x,
	input  wire logic [15:0]        pos_y,
	input  wire logic [7:0]         motion_buttons,
	input  wire logic [1:0]         button_action,
	input  wire logic [3:0]         button_number,
	input  wire ppt_pkg::cfg_t      cfg,
	input  wire logic               q_full,
	output logic                    push,
	output ppt_pkg::item_t          push_item
);

	logic [15:0] off_x;
	logic [15:0] off_y;
	logic [11:0] abs_x;
	logic [11:0] abs_y;
	logic        move;
	logic        bn_ok;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	assign off_x = pos_x - {4'd0, cfg.offset_x};
	assign off_y = pos_y - {4'd0, cfg.offset_y};
	assign abs_x = ppt_pkg::clamp_axis(off_x, ppt_pkg::lim_max(cfg.screen_width));
	assign abs_y = ppt_pkg::clamp_axis(off_y, ppt_pkg::lim_max(cfg.screen_height));
	assign move  = (pos_x != 16'd0) || (pos_y != 16'd0);
	assign bn_ok = (button_number >= 4'd1) && (button_number <= 4'd8);

	always_comb begin
		push_item          = '0;
		push_item.op       = ppt_pkg::OP_NONE;
		push_item.relative = relative;
		push_item.dx       = pos_x;
		push_item.dy       = pos_y;
		push_item.abs_x    = abs_x;
		push_item.abs_y    = abs_y;
		push_item.use_x    = move && (abs_x != 12'd0);
		push_item.use_y    = move && (abs_y != 12'd0);
		push_item.buttons  = motion_buttons;
		push_item.bit_mask = bn_ok ? (8'd1 << (button_number[2:0] - 3'd1)) : 8'd0;
		push_item.posted   = 1'b0;
		unique case (cmd)
			ppt_pkg::CMD_MOTION: begin
				if (cfg.surface_present) begin
					push_item.op     = ppt_pkg::OP_MOTION;
					push_item.posted = cfg.motion_enable;
				end
			end
			ppt_pkg::CMD_BUTTON: begin
				if (button_action == ppt_pkg::ACT_PRESS) begin
					push_item.op     = ppt_pkg::OP_PRESS;
					push_item.posted = cfg.press_enable;
				end else if (button_action == ppt_pkg::ACT_RELEASE) begin
					push_item.op     = ppt_pkg::OP_RELEASE;
					push_item.posted = cfg.release_enable;
				end
			end
			ppt_pkg::CMD_READ: begin
				push_item.op = ppt_pkg::OP_READ;
			end
			default: begin
				push_item.op = ppt_pkg::OP_NONE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/ppt_queue.sv @@
// Short FIFO of decoded items between front and back end.
// Uses ppt_pkg item type and the assertion macros header.
`default_nettype none
`include "pointer_position_tracker_defines.svh"

module ppt_queue #(
	parameter int DEPTH = ppt_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire ppt_pkg::item_t push_item,
	output logic                full,
	output logic                q_valid,
	output ppt_pkg::item_t      head,
	input  wire logic           pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ppt_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`PPT_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "queue count above depth")
	`PPT_ASSERT(a_pop_nonempty, !pop || q_valid, "pop from empty queue")
	`PPT_ASSERT_NEXT(a_push_grows, push && !pop, count_q == $past(count_q) + 1'b1, "push lost")

endmodule

`default_nettype wire

@@ hw/rtl/ppt_back.sv @@
// Back end: applies decoded items to pointer, button and delta state and
// holds the result register. Uses ppt_pkg and the assertion macros header.
`default_nettype none
`include "pointer_position_tracker_defines.svh"

module ppt_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ppt_pkg::cfg_t   cfg,
	input  wire logic            q_valid,
	input  wire ppt_pkg::item_t  head,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output ppt_pkg::result_t     res
);

	logic [11:0] pointer_x_q;
	logic [11:0] pointer_y_q;
	logic [15:0] sum_x_q;
	logic [15:0] sum_y_q;
	logic [7:0]  mask_q;
	logic        out_valid_q;
	ppt_pkg::result_t res_q;

	logic [15:0] rel_x;
	logic [15:0] rel_y;
	logic [11:0] mot_x;
	logic [11:0] mot_y;
	logic [15:0] rx;
	logic [15:0] ry;
	logic [11:0] bx;
	logic [11:0] by;
	logic [11:0] nx_px;
	logic [11:0] nx_py;
	logic [15:0] nx_sx;
	logic [15:0] nx_sy;
	logic [7:0]  nx_mask;
	logic        clear;
	ppt_pkg::result_t nx_res;

	assign pop       = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	assign rel_x = {4'd0, pointer_x_q} + head.dx;
	assign rel_y = {4'd0, pointer_y_q} + head.dy;
	assign mot_x = head.relative ?
		ppt_pkg::clamp_axis(rel_x, ppt_pkg::lim_max(cfg.screen_width)) : head.abs_x;
	assign mot_y = head.relative ?
		ppt_pkg::clamp_axis(rel_y, ppt_pkg::lim_max(cfg.screen_height)) : head.abs_y;
	assign rx = head.relative ? head.dx : ({4'd0, mot_x} - {4'd0, pointer_x_q});
	assign ry = head.relative ? head.dy : ({4'd0, mot_y} - {4'd0, pointer_y_q});
	assign bx = head.use_x ? head.abs_x : pointer_x_q;
	assign by = head.use_y ? head.abs_y : pointer_y_q;

	always_comb begin
		nx_px   = pointer_x_q;
		nx_py   = pointer_y_q;
		nx_sx   = sum_x_q;
		nx_sy   = sum_y_q;
		nx_mask = mask_q;
		clear   = 1'b0;
		nx_res  = '0;
		nx_res.event_kind = ppt_pkg::EV_NONE;
		unique case (head.op)
			ppt_pkg::OP_MOTION: begin
				nx_px   = mot_x;
				nx_py   = mot_y;
				nx_sx   = sum_x_q + rx;
				nx_sy   = sum_y_q + ry;
				nx_mask = (head.buttons != 8'd0) ? head.buttons : mask_q;
				nx_res.posted     = head.posted;
				nx_res.event_kind = ppt_pkg::EV_MOTION;
				nx_res.event_x    = mot_x;
				nx_res.event_y    = mot_y;
				nx_res.step_rel_x = rx;
				nx_res.step_rel_y = ry;
			end
			ppt_pkg::OP_PRESS: begin
				nx_px   = bx;
				nx_py   = by;
				nx_mask = mask_q | head.bit_mask;
				nx_res.posted     = head.posted;
				nx_res.event_kind = ppt_pkg::EV_DOWN;
				nx_res.event_x    = bx;
				nx_res.event_y    = by;
			end
			ppt_pkg::OP_RELEASE: begin
				nx_px   = bx;
				nx_py   = by;
				nx_mask = mask_q & ~head.bit_mask;
				nx_res.posted     = head.posted;
				nx_res.event_kind = ppt_pkg::EV_UP;
				nx_res.event_x    = bx;
				nx_res.event_y    = by;
			end
			ppt_pkg::OP_READ: begin
				clear = 1'b1;
			end
			default: begin
				clear = 1'b0;
			end
		endcase
		nx_res.cur_x       = nx_px;
		nx_res.cur_y       = nx_py;
		nx_res.cur_buttons = nx_mask;
		nx_res.sum_dx      = nx_sx;
		nx_res.sum_dy      = nx_sy;
	end

	always_ff @(posedge clk) begin
		if (pop)
			res_q <= nx_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pointer_x_q <= '0;
			pointer_y_q <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= pop || (out_valid_q && out_stall);
			if (pop) begin
				pointer_x_q <= nx_px;
				pointer_y_q <= nx_py;
				mask_q      <= nx_mask;
				sum_x_q     <= clear ? 16'd0 : nx_sx;
				sum_y_q     <= clear ? 16'd0 : nx_sy;
			end
		end
	end

	`PPT_ASSERT_NEXT(a_read_clears, pop && head.op == ppt_pkg::OP_READ,
		sum_x_q == 16'd0 && sum_y_q == 16'd0, "delta sums not cleared on read")
	`PPT_ASSERT_NEXT(a_cur_matches, pop,
		res_q.cur_x == pointer_x_q && res_q.cur_y == pointer_y_q && res_q.cur_buttons == mask_q,
		"reported state differs from stored state")
	`PPT_ASSERT(a_valid_from_pop, !$rose(out_valid_q) || $past(pop), "result without item")

endmodule

`default_nettype wire

@@ hw/rtl/pointer_position_tracker.sv @@
// Pointer position tracker top level: configuration registers, front end,
// item queue and back end. Uses ppt_pkg, ppt_front, ppt_queue, ppt_back.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_stall    cmd .. button_number
//   out       source     out_valid / out_stall  posted .. sum_dy
//   cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; an accepted item passes
// the queue register, then the result register in the back end.
// The back end updates state from combinational relative add, clamp and mask logic.
// A stalled result holds; the queue of QUEUE_DEPTH items absorbs stalls before
// in_stall rises. cfg_ready is always high. Reset clears state, config to defaults.
`default_nettype none

module pointer_position_tracker #(
	parameter int QUEUE_DEPTH = ppt_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic               relative,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic [7:0]         motion_buttons,
	input  wire logic [1:0]         button_action,
	input  wire logic [3:0]         button_number,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    posted,
	output logic [1:0]              event_kind,
	output logic [11:0]             event_x,
	output logic [11:0]             event_y,
	output logic signed [15:0]      step_rel_x,
	output logic signed [15:0]      step_rel_y,
	output logic [11:0]             cur_x,
	output logic [11:0]             cur_y,
	output logic [7:0]              cur_buttons,
	output logic signed [15:0]      sum_dx,
	output logic signed [15:0]      sum_dy,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [12:0]        cfg_data
);

	ppt_pkg::cfg_t    cfg_q;
	ppt_pkg::item_t   push_item;
	ppt_pkg::item_t   head;
	ppt_pkg::result_t res;
	logic             push;
	logic             q_full;
	logic             q_valid;
	logic             pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width    <= ppt_pkg::RST_SCREEN_WIDTH;
			cfg_q.screen_height   <= ppt_pkg::RST_SCREEN_HEIGHT;
			cfg_q.offset_x        <= '0;
			cfg_q.offset_y        <= '0;
			cfg_q.surface_present <= 1'b1;
			cfg_q.motion_enable   <= 1'b1;
			cfg_q.press_enable    <= 1'b1;
			cfg_q.release_enable  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ppt_pkg::REG_SCREEN_WIDTH:   cfg_q.screen_width    <= cfg_data;
				ppt_pkg::REG_SCREEN_HEIGHT:  cfg_q.screen_height   <= cfg_data;
				ppt_pkg::REG_OFFSET_X:       cfg_q.offset_x        <= cfg_data[11:0];
				ppt_pkg::REG_OFFSET_Y:       cfg_q.offset_y        <= cfg_data[11:0];
				ppt_pkg::REG_SURFACE:        cfg_q.surface_present <= cfg_data[0];
				ppt_pkg::REG_MOTION_ENABLE:  cfg_q.motion_enable   <= cfg_data[0];
				ppt_pkg::REG_PRESS_ENABLE:   cfg_q.press_enable    <= cfg_data[0];
				ppt_pkg::REG_RELEASE_ENABLE: cfg_q.release_enable  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	ppt_front u_front (
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.relative       (relative),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.motion_buttons (motion_buttons),
		.button_action  (button_action),
		.button_number  (button_number),
		.cfg            (cfg_q),
		.q_full         (q_full),
		.push           (push),
		.push_item      (push_item)
	);

	ppt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.q_valid   (q_valid),
		.head      (head),
		.pop       (pop)
	);

	ppt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign posted      = res.posted;
	assign event_kind  = res.event_kind;
	assign event_x     = res.event_x;
	assign event_y     = res.event_y;
	assign step_rel_x  = res.step_rel_x;
	assign step_rel_y  = res.step_rel_y;
	assign cur_x       = res.cur_x;
	assign cur_y       = res.cur_y;
	assign cur_buttons = res.cur_buttons;
	assign sum_dx      = res.sum_dx;
	assign sum_dy      = res.sum_dy;

endmodule

`default_nettype wire
